### design/lc3_instruction_core_assert.svh
// assertion macros for the lc3 instruction core
// included by the top level only
`ifndef LC3_INSTRUCTION_CORE_ASSERT_SVH
`define LC3_INSTRUCTION_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LC3_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LC3_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lc3_pkg.sv
// shared types and constants for the lc3 instruction core
// no dependencies
package lc3_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;

    localparam logic [1:0] CMD_STEP   = 2'd0;
    localparam logic [1:0] CMD_MEM_WR = 2'd1;
    localparam logic [1:0] CMD_MEM_RD = 2'd2;
    localparam logic [1:0] CMD_REG_WR = 2'd3;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_HALTED  = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_TRAP    = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    localparam logic [7:0]  HALT_VECTOR = 8'h25;
    localparam logic [15:0] START_RESET = 16'h3000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [2:0]  reg_index;
        logic [15:0] data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] next_pc;
        logic [7:0]  trap_vector;
        logic [15:0] r0_value;
        logic [15:0] read_data;
        logic [2:0]  cond_code;
    } t_out_item;

    // address source for the memory port
    typedef enum logic [1:0] {
        MA_ITEM = 2'd0,
        MA_PC   = 2'd1,
        MA_EA   = 2'd2,
        MA_MDR  = 2'd3
    } t_maddr_sel;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       mem_rd;
        t_maddr_sel maddr_sel;
        logic       load_ir;
        logic       load_mdr;
        logic       execute;
        logic       load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       halted;
        logic [3:0] opcode;
    } t_status;

    function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < 16; i++) begin
            if (i >= bits) r[i] = v[bits-1];
        end
        return r;
    endfunction

endpackage

### design/lc3_ctrl.sv
// controller state machine for the lc3 instruction core
// depends on lc3_pkg
module lc3_ctrl import lc3_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    input  t_status i_stat,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_IND   = 7'b0010000,
        S_EXEC  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_take;

    // input is taken only in idle
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_take      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.maddr_sel = MA_ITEM;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.cmd == CMD_STEP && !i_stat.halted) begin
                    o_cmd.mem_rd    = 1'b1;
                    o_cmd.maddr_sel = MA_PC;
                    n_state = S_FETCH;
                end else begin
                    if (i_stat.cmd == CMD_MEM_RD) o_cmd.mem_rd = 1'b1;
                    o_cmd.execute = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_FETCH: begin
                o_cmd.load_ir = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                // ea based memory read for loads and indirect stores
                o_cmd.maddr_sel = MA_EA;
                o_cmd.mem_rd = (i_stat.opcode == OP_LD) || (i_stat.opcode == OP_LDR)
                    || (i_stat.opcode == OP_LDI) || (i_stat.opcode == OP_STI);
                if ((i_stat.opcode == OP_LDI) || (i_stat.opcode == OP_STI)) begin
                    n_state = S_IND;
                end else begin
                    o_cmd.execute = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_IND: begin
                // pointer word is in the read register now
                o_cmd.maddr_sel = MA_MDR;
                o_cmd.mem_rd    = (i_stat.opcode == OP_LDI);
                o_cmd.execute   = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.load_mdr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/lc3_dpath.sv
// datapath of the lc3 instruction core: registers, memory, alu
// depends on lc3_pkg
module lc3_dpath import lc3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_status     o_stat,
    output t_out_item   o_out
);

    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_mem_q;
    logic [15:0] r_rf [8];
    logic [15:0] r_pc, r_ir;
    logic [2:0]  r_cc;
    logic        r_halted;
    t_in_item    r_item;
    logic [2:0]  r_status;
    logic [7:0]  r_vec;
    logic [15:0] r_rd;
    logic        r_ld_pending;
    logic [2:0]  r_ld_dr;
    t_out_item   r_out;

    logic [ADDR_BITS-1:0] w_maddr;
    logic [15:0] w_pc1, w_sr1, w_drv, w_b, w_ea, w_res;
    logic [3:0]  w_op;
    logic [2:0]  w_dr, w_sr1i;

    assign w_op   = r_ir[15:12];
    assign w_dr   = r_ir[11:9];
    assign w_sr1i = r_ir[8:6];
    assign w_pc1  = r_pc;
    assign w_sr1  = r_rf[w_sr1i];
    assign w_drv  = r_rf[w_dr];
    assign w_b    = r_ir[5] ? sext(r_ir, 5) : r_rf[r_ir[2:0]];
    assign w_ea   = ((w_op == OP_LDR) || (w_op == OP_STR)) ? w_sr1 + sext(r_ir, 6)
                                                            : w_pc1 + sext(r_ir, 9);

    always_comb begin
        unique case (i_cmd.maddr_sel)
            MA_ITEM: w_maddr = r_item.addr[ADDR_BITS-1:0];
            MA_PC:   w_maddr = r_pc[ADDR_BITS-1:0];
            MA_EA:   w_maddr = w_ea[ADDR_BITS-1:0];
            MA_MDR:  w_maddr = r_mem_q[ADDR_BITS-1:0];
            default: w_maddr = r_item.addr[ADDR_BITS-1:0];
        endcase
    end

    assign o_stat.cmd    = r_item.cmd;
    assign o_stat.halted = r_halted;
    assign o_stat.opcode = w_op;
    assign o_out = r_out;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        priority if (v == 16'h0) return 3'b010;
        else if (v[15])          return 3'b100;
        else                     return 3'b001;
    endfunction

    // memory: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) r_mem_q <= r_mem[w_maddr];
        if (i_cmd.execute && r_item.cmd == CMD_MEM_WR)
            r_mem[r_item.addr[ADDR_BITS-1:0]] <= r_item.data;
        if (i_cmd.execute && r_item.cmd == CMD_STEP && !r_halted) begin
            unique case (w_op)
                OP_ST, OP_STR: r_mem[w_ea[ADDR_BITS-1:0]] <= w_drv;
                OP_STI:        r_mem[r_mem_q[ADDR_BITS-1:0]] <= w_drv;
                default: ;
            endcase
        end
    end

    // alu result for register-writing ops other than loads
    always_comb begin
        unique case (w_op)
            OP_ADD:  w_res = w_sr1 + w_b;
            OP_AND:  w_res = w_sr1 & w_b;
            OP_NOT:  w_res = ~w_sr1;
            default: w_res = w_pc1 + sext(r_ir, 9);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in;
            r_rd   <= '0;
        end
        if (i_cmd.load_ir) begin
            r_ir <= r_mem_q;
            r_rd <= r_mem_q;
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_status;
            r_out.next_pc     <= r_pc;
            r_out.trap_vector <= r_vec;
            r_out.r0_value    <= r_rf[0];
            r_out.read_data   <= (r_item.cmd == CMD_MEM_RD) ? r_mem_q : r_rd;
            r_out.cond_code   <= r_cc;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_rf[i] <= '0;
            r_pc         <= START_RESET;
            r_cc         <= '0;
            r_halted     <= 1'b0;
            r_ld_pending <= 1'b0;
            r_ld_dr      <= '0;
            r_status     <= ST_DONE;
            r_vec        <= '0;
        end else if (i_cfg_we) begin
            r_pc     <= i_cfg_data;
            r_halted <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                r_status <= ST_DONE;
                r_vec    <= '0;
            end
            if (i_cmd.load_ir) r_pc <= r_pc + 16'd1;
            // loaded word arrives in r_mem_q in the cycle after execute
            if (i_cmd.load_mdr && r_ld_pending) begin
                r_rf[r_ld_dr] <= r_mem_q;
                r_cc          <= cc_of(r_mem_q);
            end
            if (i_cmd.load_mdr) r_ld_pending <= 1'b0;
            if (i_cmd.execute) begin
                unique case (r_item.cmd)
                    CMD_REG_WR: r_rf[r_item.reg_index] <= r_item.data;
                    CMD_STEP: begin
                        if (r_halted) begin
                            r_status <= ST_IGNORED;
                        end else begin
                            unique case (w_op)
                                OP_BR: begin
                                    if ((w_dr & r_cc) != 3'b0)
                                        r_pc <= w_pc1 + sext(r_ir, 9);
                                end
                                OP_ADD, OP_AND, OP_NOT: begin
                                    r_rf[w_dr] <= w_res;
                                    r_cc       <= cc_of(w_res);
                                end
                                OP_LEA: r_rf[w_dr] <= w_res;
                                OP_LD, OP_LDR, OP_LDI: begin
                                    r_ld_pending <= 1'b1;
                                    r_ld_dr      <= w_dr;
                                end
                                OP_JSR: begin
                                    r_pc <= r_ir[11] ? w_pc1 + sext(r_ir, 11) : w_sr1;
                                    r_rf[7] <= w_pc1;
                                end
                                OP_JMP: r_pc <= w_sr1;
                                OP_TRAP: begin
                                    r_vec <= r_ir[7:0];
                                    if (r_ir[7:0] == HALT_VECTOR) begin
                                        r_pc     <= '0;
                                        r_halted <= 1'b1;
                                        r_status <= ST_HALTED;
                                    end else begin
                                        r_status <= ST_TRAP;
                                    end
                                end
                                default: ;
                            endcase
                            if (r_ir == 16'h0) r_status <= ST_ZERO;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

### design/lc3_instruction_core.sv
// lc3 instruction core: one item at a time, result valid after the item has passed through the states below
// step: dispatch, fetch, decode, execute, result; ldi and sti add an indirect read after decode
// memory and register commands, and steps while halted: dispatch, execute, result
// the next transfer waits for the idle state, which the result state leaves only once the output is free
// synchronous active-low reset: registers zero, pc = 0x3000, cc zero, not halted; memory kept
// a start_address write reloads pc and clears halt
module lc3_instruction_core import lc3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

`include "lc3_instruction_core_assert.svh"

    t_cmd    w_cmd;
    t_status w_stat;

    assign o_cfg_ready = 1'b1;

    lc3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    lc3_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out_data)
    );

    `LC3_ASSERT_IMP(a_load_out_idle, i_clk, i_rst_n, w_cmd.load_out, !w_cmd.load_item, "result load overlaps item load")
    `LC3_ASSERT_NXT(a_load_out_valid, i_clk, i_rst_n, w_cmd.load_out, o_out_valid, "result not presented after load")
    `LC3_ASSERT_NXT(a_take_busy, i_clk, i_rst_n, w_cmd.load_item, o_in_stall, "input not stalled while working")

endmodule

### verif/testbench.sv
// self-checking testbench for the lc3 instruction core
// depends on lc3_pkg and lc3_instruction_core; predicts every result in the testbench
module testbench;
    import lc3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    lc3_instruction_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // shadow core state
    logic [15:0] cpu_regs [8];
    logic [15:0] cpu_pc;
    logic [2:0]  cpu_cc;
    logic        cpu_halted;
    logic [15:0] cpu_mem [int];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int          mismatches;
    int          results_seen;
    int          steps_run;
    longint      cycle_count;
    logic        pause_sender;
    int          send_gap;
    int          recv_gap;

    function automatic logic [15:0] sx(input logic [15:0] v, input int bits);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) r[i] = (i < bits) ? v[i] : v[bits-1];
        return r;
    endfunction

    function automatic logic [15:0] mem_load(input logic [15:0] a);
        return cpu_mem.exists(a) ? cpu_mem[a] : 16'h0;
    endfunction

    function automatic void set_flags(input logic [15:0] v);
        cpu_cc = (v == 0) ? 3'd2 : (v[15] ? 3'd4 : 3'd1);
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < 8; i++) cpu_regs[i] = '0;
        cpu_pc = START_RESET;
        cpu_cc = '0;
        cpu_halted = 1'b0;
    endfunction

    // runs one instruction on the shadow state
    function automatic void run_instruction(ref t_out_item res);
        logic [15:0] ir, pc1, b, ea;
        logic [2:0]  dr, sr1;
        ir  = mem_load(cpu_pc);
        pc1 = cpu_pc + 16'd1;
        dr  = ir[11:9];
        sr1 = ir[8:6];
        b   = ir[5] ? sx(ir, 5) : cpu_regs[ir[2:0]];
        res.read_data = ir;
        cpu_pc = pc1;
        case (ir[15:12])
            OP_BR:  if (ir[11:9] & cpu_cc) cpu_pc = pc1 + sx(ir, 9);
            OP_ADD: begin
                cpu_regs[dr] = cpu_regs[sr1] + b;
                set_flags(cpu_regs[dr]);
            end
            OP_LD: begin
                cpu_regs[dr] = mem_load(pc1 + sx(ir, 9));
                set_flags(cpu_regs[dr]);
            end
            OP_ST:  cpu_mem[pc1 + sx(ir, 9)] = cpu_regs[dr];
            OP_JSR: begin
                cpu_pc = ir[11] ? pc1 + sx(ir, 11) : cpu_regs[sr1];
                cpu_regs[7] = pc1;
            end
            OP_AND: begin
                cpu_regs[dr] = cpu_regs[sr1] & b;
                set_flags(cpu_regs[dr]);
            end
            OP_LDR: begin
                cpu_regs[dr] = mem_load(cpu_regs[sr1] + sx(ir, 6));
                set_flags(cpu_regs[dr]);
            end
            OP_STR: cpu_mem[cpu_regs[sr1] + sx(ir, 6)] = cpu_regs[dr];
            OP_NOT: begin
                cpu_regs[dr] = ~cpu_regs[sr1];
                set_flags(cpu_regs[dr]);
            end
            OP_LDI: begin
                cpu_regs[dr] = mem_load(mem_load(pc1 + sx(ir, 9)));
                set_flags(cpu_regs[dr]);
            end
            OP_STI: begin
                ea = mem_load(pc1 + sx(ir, 9));
                cpu_mem[ea] = cpu_regs[dr];
            end
            OP_JMP: cpu_pc = cpu_regs[sr1];
            OP_LEA: cpu_regs[dr] = pc1 + sx(ir, 9);
            OP_TRAP: begin
                res.trap_vector = ir[7:0];
                if (ir[7:0] == HALT_VECTOR) begin
                    cpu_pc = '0;
                    cpu_halted = 1'b1;
                    res.status = ST_HALTED;
                end else begin
                    res.status = ST_TRAP;
                end
            end
            default: ;
        endcase
        if (ir == 16'h0) res.status = ST_ZERO;
    endfunction

    function automatic t_out_item predict_core(input t_in_item it);
        t_out_item res;
        res = '0;
        case (it.cmd)
            CMD_STEP:
                if (cpu_halted) res.status = ST_IGNORED;
                else run_instruction(res);
            CMD_MEM_WR: cpu_mem[it.addr] = it.data;
            CMD_MEM_RD: res.read_data = mem_load(it.addr);
            default: cpu_regs[it.reg_index] = it.data;
        endcase
        res.next_pc  = cpu_pc;
        res.r0_value = cpu_regs[0];
        res.cond_code = cpu_cc;
        return res;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: one item per transfer, random gap before each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            expected_results.push_back(predict_core(i_in_data));
            if (i_in_data.cmd == CMD_STEP) steps_run++;
            if (send_gap == 0 && pending_items.size() > 0 && !pause_sender) begin
                i_in_data  <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
            send_gap <= $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
        end else if (!i_in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() > 0 && !pause_sender) begin
                i_in_data  <= pending_items.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // monitor: random stall, compare each transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap    <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", o_out_data);
                end else begin
                    t_out_item want;
                    want = expected_results.pop_front();
                    if (want !== o_out_data) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, o_out_data);
                    end
                end
                recv_gap <= $urandom_range(0, 7) * ($urandom_range(0, 2) != 0);
            end
            if (recv_gap > 0) begin
                i_out_stall <= 1'b1;
                if (!(o_out_valid && !i_out_stall)) recv_gap <= recv_gap - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_in_item make_item(input logic [1:0] c, input logic [15:0] a,
                                           input logic [2:0] r, input logic [15:0] d);
        t_in_item it;
        it.cmd = c;
        it.addr = a;
        it.reg_index = r;
        it.data = d;
        return it;
    endfunction

    // send everything queued, then hold the sender until every result is back
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid)
            @(negedge i_clk);
        pause_sender = 1'b1;
        while (expected_results.size() > 0)
            @(negedge i_clk);
        repeat (12) @(posedge i_clk);
        pause_sender = 1'b0;
    endtask

    task automatic write_start(input logic [15:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cpu_pc = v;
        cpu_halted = 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // random program at base: code in words 0..31 (zero filled past the program),
    // pointer words at 32..39 that aim into the data words at 40..55;
    // r6 is the ldr/str base and is never a destination, so every read hits written memory
    task automatic load_program(input logic [15:0] base, input int len);
        logic [15:0] w;
        logic [3:0] op;
        for (int i = 0; i < 8; i++)
            pending_items.push_back(make_item(CMD_MEM_WR, base + 16'd32 + i[15:0], 3'($urandom),
                                    base + 16'd40 + 16'($urandom_range(0, 15))));
        for (int i = 0; i < 16; i++)
            pending_items.push_back(make_item(CMD_MEM_WR, base + 16'd40 + i[15:0], 3'($urandom),
                                    rand_word()));
        for (int r = 0; r < 8; r++)
            pending_items.push_back(make_item(CMD_REG_WR, rand_word(), r[2:0],
                                    (r == 6) ? base + 16'd40 + 16'($urandom_range(0, 7))
                                             : rand_word()));
        for (int i = 0; i < 32; i++) begin
            if (i < len) begin
                w = $urandom_range(0, 65535);
                op = w[15:12];
                case (op)
                    OP_LD, OP_LEA:  w[8:0] = 9'(32 - i - 1 + $urandom_range(0, 23));
                    OP_LDI, OP_STI: w[8:0] = 9'(32 - i - 1 + $urandom_range(0, 7));
                    OP_ST:          w[8:0] = 9'(40 - i - 1 + $urandom_range(0, 15));
                    OP_LDR, OP_STR: begin
                        w[8:6] = 3'd6;
                        w[5:0] = 6'($urandom_range(0, 7));
                    end
                    OP_BR: w[8:0] = 9'(1);
                    OP_JSR: w = {OP_JSR, 1'b1, 11'd1};
                    OP_JMP: w = {OP_BR, 3'b111, 9'd1};
                    OP_TRAP: w[7:0] = ($urandom_range(0, 3) == 0) ? HALT_VECTOR : 8'($urandom);
                    default: ;
                endcase
                if ((op == OP_ADD || op == OP_AND || op == OP_NOT || op == OP_LD
                     || op == OP_LDI || op == OP_LDR || op == OP_LEA) && w[11:9] == 3'd6)
                    w[11:9] = 3'd5;
            end else begin
                w = 16'h0;
            end
            pending_items.push_back(make_item(CMD_MEM_WR, base + i[15:0], 3'($urandom), w));
        end
    endtask

    initial begin
        logic [15:0] base;
        int n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        pause_sender = 1'b0;
        mismatches = 0;
        results_seen = 0;
        steps_run = 0;
        cycle_count = 0;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes at reset pc, halt, ignored step, zero word
        pending_items.push_back(make_item(CMD_MEM_WR, START_RESET, 3'd7, {OP_ADD, 3'd0, 3'd0, 1'b1, 5'h1F}));
        pending_items.push_back(make_item(CMD_MEM_WR, 16'hFFFF, 3'd0, 16'hFFFF));
        pending_items.push_back(make_item(CMD_MEM_RD, 16'hFFFF, 3'd0, 16'h0));
        pending_items.push_back(make_item(CMD_MEM_WR, 16'h0000, 3'd0, 16'h0000));
        pending_items.push_back(make_item(CMD_MEM_RD, 16'h0000, 3'd7, 16'hFFFF));
        pending_items.push_back(make_item(CMD_REG_WR, 16'hFFFF, 3'd7, 16'hFFFF));
        pending_items.push_back(make_item(CMD_REG_WR, 16'h0, 3'd0, 16'h7FFF));
        pending_items.push_back(make_item(CMD_STEP, 16'h0, 3'd0, 16'h0));
        pending_items.push_back(make_item(CMD_MEM_WR, START_RESET + 16'd1, 3'd0, {OP_LEA, 3'd1, 9'h1FF}));
        pending_items.push_back(make_item(CMD_MEM_WR, START_RESET + 16'd2, 3'd0, {OP_TRAP, 4'd0, 8'h21}));
        pending_items.push_back(make_item(CMD_MEM_WR, START_RESET + 16'd3, 3'd0, {4'd8, 12'h0}));
        pending_items.push_back(make_item(CMD_MEM_WR, START_RESET + 16'd4, 3'd0, {4'd13, 12'hFFF}));
        pending_items.push_back(make_item(CMD_MEM_WR, START_RESET + 16'd5, 3'd0, {OP_TRAP, 4'd0, HALT_VECTOR}));
        for (int i = 0; i < 6; i++) pending_items.push_back(make_item(CMD_STEP, 16'h0, 3'd0, 16'h0));
        pending_items.push_back(make_item(CMD_MEM_RD, START_RESET, 3'd0, 16'h0));
        drain();
        write_start(16'h0000);
        pending_items.push_back(make_item(CMD_STEP, 16'h0, 3'd0, 16'h0));
        drain();
        write_start(16'hFFFF);
        pending_items.push_back(make_item(CMD_MEM_RD, 16'hFFFF, 3'd0, 16'h0));
        pending_items.push_back(make_item(CMD_STEP, 16'h0, 3'd0, 16'h0));
        drain();

        // random programs, each run from a fresh start address
        for (int p = 0; p < 15; p++) begin
            base = 16'($urandom_range(0, 1000)) * 16'd64;
            n = $urandom_range(6, 12);
            load_program(base, n);
            drain();
            write_start(base);
            for (int i = 0; i < n + 3; i++) begin
                if ($urandom_range(0, 9) == 0)
                    pending_items.push_back(make_item(CMD_MEM_RD, base + 16'($urandom_range(0, 55)),
                                            3'($urandom), 16'($urandom)));
                else
                    pending_items.push_back(make_item(CMD_STEP, 16'($urandom), 3'($urandom),
                                            16'($urandom)));
            end
            drain();
        end

        $display("covered %0d results, %0d step commands, random programs with halt and traps",
                 results_seen, steps_run);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end
endmodule
